@@ hdl/stc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the scope trigger capture block
// Field widths, command and phase codes, register indexes, the transaction
// structs passed between the capture modules and the ring length helper.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int CHANNELS    = 4;
  localparam int MAX_FRAMES  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = FRAME_W + 1;
  localparam int FRAME_BITS  = CHANNELS * SAMPLE_BITS;
  localparam int CHAN_SEL_W  = 2;

  localparam int SCOUNT_W    = 11;
  localparam int OFFSET_W    = 13;
  localparam int POST_W      = 13;
  localparam int WORD_W      = 16;
  localparam int OFF_EXT_W   = ((OFFSET_W > COUNT_W) ? OFFSET_W : COUNT_W) + 1;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam int MOD_STEP_W  = $clog2(FRAME_W);
  localparam int MOD_SHIFT_W = COUNT_W + FRAME_W - 1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_MANUAL = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_STOP = 2'd0,
    PH_PRE  = 2'd1,
    PH_WAIT = 2'd2,
    PH_POST = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TRIG_NONE = 2'd0,
    TRIG_RISE = 2'd1,
    TRIG_FALL = 2'd2,
    TRIG_BOTH = 2'd3
  } edge_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRIGGER_MODE    = 3'd0,
    REG_TRIGGER_LEVEL   = 3'd1,
    REG_TRIGGER_CHANNEL = 3'd2,
    REG_TRIGGER_OFFSET  = 3'd3,
    REG_SAMPLE_COUNT    = 3'd4,
    REG_DECIMATION      = 3'd5,
    REG_AUTO_DELAY      = 3'd6
  } reg_index_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] frame_t;

  typedef struct packed {
    edge_mode_t                 trigger_mode;
    logic [WORD_W-1:0]          trigger_level;
    logic [CHAN_SEL_W-1:0]      trigger_channel;
    logic [OFFSET_W-1:0]        trigger_offset;
    logic [SCOUNT_W-1:0]        sample_count;
    logic [WORD_W-1:0]          decimation;
    logic [WORD_W-1:0]          auto_delay;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    frame_t             samples;
    logic [FRAME_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    phase_t             capture_state;
    logic [FRAME_W-1:0] write_position;
    logic               frame_recorded;
    logic               read_valid;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    frame_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
  } ram_rd_t;

  function automatic logic [COUNT_W-1:0] ring_len(input logic [SCOUNT_W-1:0] sc);
    if (sc == '0) begin
      return COUNT_W'(1);
    end else if (32'(sc) > MAX_FRAMES) begin
      return COUNT_W'(MAX_FRAMES);
    end else begin
      return COUNT_W'(sc);
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/stc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     write_en,
  input  wire logic [$clog2(DEPTH)-1:0] write_addr,
  input  wire logic [WIDTH-1:0]         write_data,
  input  wire logic                     read_en,
  input  wire logic [$clog2(DEPTH)-1:0] read_addr,
  output      logic [WIDTH-1:0]         read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
    if (read_en) begin
      read_data <= mem[read_addr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/stc_ptr_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_ptr_mod: ring pointer modulo ring length
// Holds the write pointer reduced modulo the ring length. A ring length write
// starts a restoring reduction, one bit per cycle; a recorded frame sets the
// value directly.
// ----------------------------------------------------------------------------
module stc_ptr_mod
  import stc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                set_en,
  input  wire logic [FRAME_W-1:0]  set_value,
  input  wire logic [FRAME_W-1:0]  ring_pointer,
  input  wire logic [SCOUNT_W-1:0] sample_count,
  output      logic                busy,
  output      logic [FRAME_W-1:0]  remainder
);

  logic [MOD_STEP_W-1:0]  step;
  logic [MOD_SHIFT_W-1:0] shifted;
  logic [FRAME_W-1:0]     remainder_next;

  always_comb begin
    shifted = MOD_SHIFT_W'(ring_len(sample_count)) << step;
    if (MOD_SHIFT_W'(remainder) >= shifted) begin
      remainder_next = remainder - shifted[FRAME_W-1:0];
    end else begin
      remainder_next = remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      remainder <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      step      <= MOD_STEP_W'(FRAME_W - 1);
      remainder <= ring_pointer;
    end else if (busy) begin
      remainder <= remainder_next;
      step      <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
      end
    end else if (set_en) begin
      remainder <= set_value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/stc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_core: trigger state machine and ring bookkeeping
// Holds phase, counters, manual flag, previous trigger sample and the ring
// pointer; works out one transaction per step and drives the store ports.
// ----------------------------------------------------------------------------
module stc_core
  import stc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               step,
  input  wire item_t              item,
  input  wire logic [FRAME_W-1:0] ptr_mod,
  output      result_t            result,
  output      logic [FRAME_W-1:0] ring_pointer,
  output      ram_wr_t            ram_wr,
  output      ram_rd_t            ram_rd,
  output      logic               ptr_set
);

  phase_t              phase;
  phase_t              phase_next;
  phase_t              ph;
  logic                manual_flag;
  logic                manual_flag_next;
  logic [COUNT_W-1:0]  pre_count;
  logic [COUNT_W-1:0]  pre_count_next;
  logic [POST_W-1:0]   post_count;
  logic [POST_W-1:0]   post_count_next;
  logic [WORD_W-1:0]   auto_count;
  logic [WORD_W-1:0]   auto_count_next;
  logic [WORD_W-1:0]   skip_count;
  logic [WORD_W-1:0]   skip_count_next;
  sample_t             prev_value;
  sample_t             prev_value_next;
  logic [FRAME_W-1:0]  ring_pointer_next;

  logic [COUNT_W-1:0]   n;
  sample_t              v;
  logic                 idle;
  logic                 rise;
  logic                 fall;
  logic                 fire;
  logic                 recorded;
  logic [COUNT_W-1:0]   ptr_inc;
  logic [OFF_EXT_W-1:0] off;
  logic [OFF_EXT_W-1:0] n_ext;
  logic [OFF_EXT_W-1:0] post_diff;
  logic                 rd_en;
  logic [COUNT_W-1:0]   rd_sum;

  always_comb begin
    n                 = ring_len(cfg.sample_count);
    phase_next        = phase;
    manual_flag_next  = manual_flag;
    pre_count_next    = pre_count;
    post_count_next   = post_count;
    auto_count_next   = auto_count;
    skip_count_next   = skip_count;
    prev_value_next   = prev_value;
    ring_pointer_next = ring_pointer;
    v                 = item.samples[cfg.trigger_channel];
    idle              = (skip_count == '0);
    ph                = phase;
    rise              = 1'b0;
    fall              = 1'b0;
    fire              = 1'b0;
    recorded          = 1'b0;
    ptr_inc           = COUNT_W'(ring_pointer) + COUNT_W'(1);
    n_ext             = OFF_EXT_W'(n);
    off               = {{(OFF_EXT_W - OFFSET_W){cfg.trigger_offset[OFFSET_W-1]}},
                         cfg.trigger_offset};
    post_diff         = '0;
    rd_en             = 1'b0;
    rd_sum            = COUNT_W'(ptr_mod) + COUNT_W'(item.read_index);

    unique case (item.cmd)
      CMD_TICK: begin
        if (ph == PH_PRE && idle) begin
          if (pre_count != '0) begin
            pre_count_next = pre_count - 1'b1;
          end else begin
            ph = PH_WAIT;
          end
        end
        if (ph == PH_WAIT) begin
          rise = ($signed(prev_value) < $signed(cfg.trigger_level)) &&
                 ($signed(v) >= $signed(cfg.trigger_level));
          fall = ($signed(prev_value) > $signed(cfg.trigger_level)) &&
                 ($signed(v) <= $signed(cfg.trigger_level));
          fire = manual_flag;
          unique case (cfg.trigger_mode)
            TRIG_NONE: fire = fire;
            TRIG_RISE: fire = fire || rise;
            TRIG_FALL: fire = fire || fall;
            TRIG_BOTH: fire = fire || rise || fall;
            default:   fire = fire;
          endcase
          if (cfg.auto_delay != '0 && idle) begin
            if (auto_count != '0) begin
              auto_count_next = auto_count - 1'b1;
            end else begin
              fire = 1'b1;
            end
          end
          if (fire) begin
            ph = PH_POST;
          end
        end
        prev_value_next = v;
        if (ph == PH_POST && idle) begin
          if (post_count != '0) begin
            post_count_next = post_count - 1'b1;
          end else begin
            ph = PH_STOP;
          end
        end
        if (ph != PH_STOP && idle) begin
          recorded          = 1'b1;
          ring_pointer_next = (ptr_inc >= n) ? '0 : ptr_inc[FRAME_W-1:0];
        end
        if (ph != PH_STOP) begin
          skip_count_next = (skip_count != '0) ? skip_count - 1'b1 : cfg.decimation;
        end
        phase_next = ph;
      end
      CMD_START: begin
        if ($signed(off) > $signed(n_ext)) begin
          off = n_ext;
        end
        post_diff        = n_ext - off;
        manual_flag_next = 1'b0;
        auto_count_next  = cfg.auto_delay;
        skip_count_next  = '0;
        pre_count_next   = ($signed(off) > 0) ? off[COUNT_W-1:0] : '0;
        post_count_next  = post_diff[POST_W-1:0];
        phase_next       = PH_PRE;
      end
      CMD_MANUAL: begin
        manual_flag_next = 1'b1;
      end
      CMD_READ: begin
        if (COUNT_W'(item.read_index) < n) begin
          rd_en = 1'b1;
          if (rd_sum >= n) begin
            rd_sum = rd_sum - n;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    result.capture_state  = phase_next;
    result.write_position = ring_pointer_next;
    result.frame_recorded = recorded;
    result.read_valid     = rd_en;
    ram_wr.en             = step && recorded;
    ram_wr.addr           = ring_pointer;
    ram_wr.data           = item.samples;
    ram_rd.en             = step && rd_en;
    ram_rd.addr           = rd_sum[FRAME_W-1:0];
    ptr_set               = step && recorded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STOP;
      manual_flag  <= 1'b0;
      pre_count    <= '0;
      post_count   <= '0;
      auto_count   <= '0;
      skip_count   <= '0;
      prev_value   <= '0;
      ring_pointer <= '0;
    end else if (step) begin
      phase        <= phase_next;
      manual_flag  <= manual_flag_next;
      pre_count    <= pre_count_next;
      post_count   <= post_count_next;
      auto_count   <= auto_count_next;
      skip_count   <= skip_count_next;
      prev_value   <= prev_value_next;
      ring_pointer <= ring_pointer_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/scope_trigger_capture_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_trigger_capture_top: multi-channel trigger and ring capture
// Configuration registers, input and result registers around the trigger
// core, the frame store and the pointer modulo unit.
//
//   channel   signals                                      handshake
//   item      cmd, sample_0..3, read_index                 item_valid/item_ready
//   result    capture_state, write_position,
//             frame_recorded, read_0..3                    result_valid/result_ready
//   config    cfg_write_en, cfg_index, cfg_data            write enable only
//
// One transaction per cycle unless a result stall or the pointer modulo unit
// holds it; each passes the input register, then the result register with
// the registered store read. A ring length write sets the pointer modulo
// unit running, one quotient bit per cycle; item_ready is low meanwhile.
// Reset clears control state only; the frame store has no clearing pass.
// A stalled result holds the core and the store read; the input register
// still takes a transaction while empty.
// ----------------------------------------------------------------------------
module scope_trigger_capture_top
  import stc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  output      logic                   item_ready,
  input  wire logic [1:0]             cmd,
  input  wire logic [SAMPLE_BITS-1:0] sample_0,
  input  wire logic [SAMPLE_BITS-1:0] sample_1,
  input  wire logic [SAMPLE_BITS-1:0] sample_2,
  input  wire logic [SAMPLE_BITS-1:0] sample_3,
  input  wire logic [FRAME_W-1:0]     read_index,
  output      logic                   result_valid,
  input  wire logic                   result_ready,
  output      logic [1:0]             capture_state,
  output      logic [FRAME_W-1:0]     write_position,
  output      logic                   frame_recorded,
  output      logic [SAMPLE_BITS-1:0] read_0,
  output      logic [SAMPLE_BITS-1:0] read_1,
  output      logic [SAMPLE_BITS-1:0] read_2,
  output      logic [SAMPLE_BITS-1:0] read_3
);

  cfg_t                    cfg;
  item_t                   item_in;
  item_t                   item_q;
  logic                    item_held;
  logic                    step;
  result_t                 result;
  result_t                 result_q;
  logic [FRAME_W-1:0]      ring_pointer;
  logic [FRAME_W-1:0]      ptr_mod;
  logic                    mod_busy;
  logic                    mod_start;
  logic                    ptr_set;
  ram_wr_t                 ram_wr;
  ram_rd_t                 ram_rd;
  logic [FRAME_BITS-1:0]   ram_rdata;
  frame_t                  rd_frame;

  assign mod_start = cfg_write_en && (reg_index_t'(cfg_index) == REG_SAMPLE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_mode    <= TRIG_RISE;
      cfg.trigger_level   <= '0;
      cfg.trigger_channel <= '0;
      cfg.trigger_offset  <= OFFSET_W'(200);
      cfg.sample_count    <= SCOUNT_W'(1024);
      cfg.decimation      <= WORD_W'(1);
      cfg.auto_delay      <= '0;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_TRIGGER_MODE:    cfg.trigger_mode    <= edge_mode_t'(cfg_data[1:0]);
        REG_TRIGGER_LEVEL:   cfg.trigger_level   <= cfg_data[WORD_W-1:0];
        REG_TRIGGER_CHANNEL: cfg.trigger_channel <= cfg_data[CHAN_SEL_W-1:0];
        REG_TRIGGER_OFFSET:  cfg.trigger_offset  <= cfg_data[OFFSET_W-1:0];
        REG_SAMPLE_COUNT:    cfg.sample_count    <= cfg_data[SCOUNT_W-1:0];
        REG_DECIMATION:      cfg.decimation      <= cfg_data[WORD_W-1:0];
        REG_AUTO_DELAY:      cfg.auto_delay      <= cfg_data[WORD_W-1:0];
        default:             cfg.auto_delay      <= cfg.auto_delay;
      endcase
    end
  end

  always_comb begin
    item_in.cmd        = cmd_t'(cmd);
    item_in.samples[0] = sample_0;
    item_in.samples[1] = sample_1;
    item_in.samples[2] = sample_2;
    item_in.samples[3] = sample_3;
    item_in.read_index = read_index;
  end

  assign step       = item_held && (!result_valid || result_ready);
  assign item_ready = !mod_busy && (!item_held || step);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        item_held <= 1'b1;
      end else if (step) begin
        item_held <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item_in;
    end
    if (step) begin
      result_q <= result;
    end
  end

  stc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (step),
    .item         (item_q),
    .ptr_mod      (ptr_mod),
    .result       (result),
    .ring_pointer (ring_pointer),
    .ram_wr       (ram_wr),
    .ram_rd       (ram_rd),
    .ptr_set      (ptr_set)
  );

  stc_ptr_mod u_ptr_mod (
    .clk          (clk),
    .rst          (rst),
    .start        (mod_start),
    .set_en       (ptr_set),
    .set_value    (result.write_position),
    .ring_pointer (ring_pointer),
    .sample_count (cfg.sample_count),
    .busy         (mod_busy),
    .remainder    (ptr_mod)
  );

  stc_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_frame_store (
    .clk        (clk),
    .write_en   (ram_wr.en),
    .write_addr (ram_wr.addr),
    .write_data (ram_wr.data),
    .read_en    (ram_rd.en),
    .read_addr  (ram_rd.addr),
    .read_data  (ram_rdata)
  );

  assign rd_frame       = ram_rdata;
  assign capture_state  = result_q.capture_state;
  assign write_position = result_q.write_position;
  assign frame_recorded = result_q.frame_recorded;
  assign read_0         = result_q.read_valid ? rd_frame[0] : '0;
  assign read_1         = result_q.read_valid ? rd_frame[1] : '0;
  assign read_2         = result_q.read_valid ? rd_frame[2] : '0;
  assign read_3         = result_q.read_valid ? rd_frame[3] : '0;

  a_record_not_stopped: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_recorded |-> capture_state != PH_STOP)
    else $error("frame recorded in stopped phase");

  a_ptr_mod_in_ring: assert property (@(posedge clk) disable iff (rst)
    !mod_busy |-> COUNT_W'(ptr_mod) < ring_len(cfg.sample_count))
    else $error("reduced pointer outside ring length");

  a_mod_start_on_write: assert property (@(posedge clk) disable iff (rst)
    $rose(mod_busy) |-> $past(cfg_write_en))
    else $error("pointer unit started without a configuration write");

endmodule
`default_nettype wire

@@ dv/scope_trigger_capture_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trigger_capture_checker: capture status and frame read predictor
// Watches the register writes, the input transactions and the result
// transactions of the capture block. It keeps its own trigger state
// machine, counters, ring pointer and frame store, predicts one status
// word per accepted transaction and compares each result with the oldest
// prediction field by field.
// ----------------------------------------------------------------------------
module scope_trigger_capture_checker
  import stc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  logic [1:0]             cmd,
  input  logic [SAMPLE_BITS-1:0] sample_0,
  input  logic [SAMPLE_BITS-1:0] sample_1,
  input  logic [SAMPLE_BITS-1:0] sample_2,
  input  logic [SAMPLE_BITS-1:0] sample_3,
  input  logic [FRAME_W-1:0]     read_index,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  logic [1:0]             capture_state,
  input  logic [FRAME_W-1:0]     write_position,
  input  logic                   frame_recorded,
  input  logic [SAMPLE_BITS-1:0] read_0,
  input  logic [SAMPLE_BITS-1:0] read_1,
  input  logic [SAMPLE_BITS-1:0] read_2,
  input  logic [SAMPLE_BITS-1:0] read_3,
  output int                     mismatch_count,
  output int                     outstanding
);

  typedef struct packed {
    phase_t             capture_state;
    logic [FRAME_W-1:0] write_position;
    logic               frame_recorded;
    frame_t             readout;
  } capture_status_t;

  edge_mode_t                  cfg_mode;
  logic signed [WORD_W-1:0]    cfg_level;
  logic [CHAN_SEL_W-1:0]       cfg_channel;
  logic signed [OFFSET_W-1:0]  cfg_offset;
  logic [SCOUNT_W-1:0]         frame_count;
  logic [WORD_W-1:0]           decimation;
  logic [WORD_W-1:0]           auto_delay;

  phase_t                      phase;
  logic                        manual_flag;
  logic [SCOUNT_W-1:0]         pre_count;
  logic [POST_W-1:0]           post_count;
  logic [WORD_W-1:0]           auto_count;
  logic [WORD_W-1:0]           skip_count;
  logic signed [WORD_W-1:0]    prev_trig;
  logic [FRAME_W-1:0]          ring_ptr;
  frame_t                      frame_store [MAX_FRAMES];

  capture_status_t             predicted_q [$];

  function automatic int ring_frames();
    if (frame_count == '0) begin
      return 1;
    end
    if (int'(frame_count) > MAX_FRAMES) begin
      return MAX_FRAMES;
    end
    return int'(frame_count);
  endfunction

  task automatic step_capture(input cmd_t c, input frame_t s,
                              input logic [FRAME_W-1:0] ri,
                              output capture_status_t st);
    int                       n;
    int                       off;
    logic                     idle;
    logic                     fire;
    logic                     rise;
    logic                     fall;
    logic signed [WORD_W-1:0] v;
    n = ring_frames();
    st = '0;
    case (c)
      CMD_TICK: begin
        v = $signed(s[cfg_channel]);
        idle = (skip_count == '0);
        if (phase == PH_PRE && idle) begin
          if (pre_count != '0) pre_count = pre_count - 1'b1;
          else phase = PH_WAIT;
        end
        if (phase == PH_WAIT) begin
          fire = manual_flag;
          rise = (prev_trig < cfg_level) && (v >= cfg_level);
          fall = (prev_trig > cfg_level) && (v <= cfg_level);
          case (cfg_mode)
            TRIG_RISE: fire = fire | rise;
            TRIG_FALL: fire = fire | fall;
            TRIG_BOTH: fire = fire | rise | fall;
            default: ;
          endcase
          if (auto_delay != '0 && idle) begin
            if (auto_count != '0) auto_count = auto_count - 1'b1;
            else fire = 1'b1;
          end
          if (fire) phase = PH_POST;
        end
        prev_trig = v;
        if (phase == PH_POST && idle) begin
          if (post_count != '0) post_count = post_count - 1'b1;
          else phase = PH_STOP;
        end
        if (phase != PH_STOP && idle) begin
          frame_store[ring_ptr] = s;
          ring_ptr = (int'(ring_ptr) + 1 >= n) ? '0 : ring_ptr + 1'b1;
          st.frame_recorded = 1'b1;
        end
        if (phase != PH_STOP) begin
          skip_count = (skip_count != '0) ? skip_count - 1'b1 : decimation;
        end
      end
      CMD_START: begin
        off = int'(cfg_offset);
        if (off > n) off = n;
        manual_flag = 1'b0;
        auto_count = auto_delay;
        skip_count = '0;
        pre_count = (off > 0) ? SCOUNT_W'(off) : '0;
        post_count = POST_W'(n - off);
        phase = PH_PRE;
      end
      CMD_MANUAL: begin
        manual_flag = 1'b1;
      end
      default: begin
        if (int'(ri) < n) begin
          st.readout = frame_store[(int'(ring_ptr) + int'(ri)) % n];
        end
      end
    endcase
    st.capture_state = phase;
    st.write_position = ring_ptr;
  endtask

  always @(posedge clk) begin
    capture_status_t want;
    capture_status_t got;
    capture_status_t next;
    if (rst) begin
      cfg_mode = TRIG_RISE;
      cfg_level = '0;
      cfg_channel = '0;
      cfg_offset = OFFSET_W'(200);
      frame_count = SCOUNT_W'(1024);
      decimation = WORD_W'(1);
      auto_delay = '0;
      phase = PH_STOP;
      manual_flag = 1'b0;
      pre_count = '0;
      post_count = '0;
      auto_count = '0;
      skip_count = '0;
      prev_trig = '0;
      ring_ptr = '0;
      predicted_q.delete();
      mismatch_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        got.capture_state = phase_t'(capture_state);
        got.write_position = write_position;
        got.frame_recorded = frame_recorded;
        got.readout = {read_3, read_2, read_1, read_0};
        if (predicted_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: state %0d pos %0d rec %0b read %h",
                     got.capture_state, got.write_position, got.frame_recorded,
                     got.readout);
          end
          mismatch_count++;
        end else begin
          want = predicted_q.pop_front();
          if (got.capture_state !== want.capture_state ||
              got.write_position !== want.write_position ||
              got.frame_recorded !== want.frame_recorded ||
              got.readout[0] !== want.readout[0] || got.readout[1] !== want.readout[1] ||
              got.readout[2] !== want.readout[2] || got.readout[3] !== want.readout[3]) begin
            if (mismatch_count < 10) begin
              $display("mismatch: expected state %0d pos %0d rec %0b read %h",
                       want.capture_state, want.write_position, want.frame_recorded,
                       want.readout);
              $display("          actual   state %0d pos %0d rec %0b read %h",
                       got.capture_state, got.write_position, got.frame_recorded,
                       got.readout);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_write_en) begin
        case (reg_index_t'(cfg_index))
          REG_TRIGGER_MODE:    cfg_mode = edge_mode_t'(cfg_data[1:0]);
          REG_TRIGGER_LEVEL:   cfg_level = cfg_data;
          REG_TRIGGER_CHANNEL: cfg_channel = cfg_data[CHAN_SEL_W-1:0];
          REG_TRIGGER_OFFSET:  cfg_offset = cfg_data[OFFSET_W-1:0];
          REG_SAMPLE_COUNT:    frame_count = cfg_data[SCOUNT_W-1:0];
          REG_DECIMATION:      decimation = cfg_data;
          REG_AUTO_DELAY:      auto_delay = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        step_capture(cmd_t'(cmd), {sample_3, sample_2, sample_1, sample_0},
                     read_index, next);
        predicted_q.push_back(next);
      end
    end
    outstanding = predicted_q.size();
  end

endmodule

@@ dv/scope_trigger_capture_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trigger_capture_top_tb: capture block testbench
// Fills the whole frame store with one long capture, runs a short directed
// set of trigger, clamp and wrap cases, then random capture sequences under
// random register settings and varying idle and stall patterns on both
// channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module scope_trigger_capture_top_tb;
  import stc_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic [1:0]             cmd = '0;
  logic [SAMPLE_BITS-1:0] sample_0 = '0;
  logic [SAMPLE_BITS-1:0] sample_1 = '0;
  logic [SAMPLE_BITS-1:0] sample_2 = '0;
  logic [SAMPLE_BITS-1:0] sample_3 = '0;
  logic [FRAME_W-1:0]     read_index = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [1:0]             capture_state;
  logic [FRAME_W-1:0]     write_position;
  logic                   frame_recorded;
  logic [SAMPLE_BITS-1:0] read_0;
  logic [SAMPLE_BITS-1:0] read_1;
  logic [SAMPLE_BITS-1:0] read_2;
  logic [SAMPLE_BITS-1:0] read_3;

  int mismatch_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  scope_trigger_capture_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .cmd            (cmd),
    .sample_0       (sample_0),
    .sample_1       (sample_1),
    .sample_2       (sample_2),
    .sample_3       (sample_3),
    .read_index     (read_index),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .capture_state  (capture_state),
    .write_position (write_position),
    .frame_recorded (frame_recorded),
    .read_0         (read_0),
    .read_1         (read_1),
    .read_2         (read_2),
    .read_3         (read_3)
  );

  scope_trigger_capture_checker i_capture_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .cmd            (cmd),
    .sample_0       (sample_0),
    .sample_1       (sample_1),
    .sample_2       (sample_2),
    .sample_3       (sample_3),
    .read_index     (read_index),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .capture_state  (capture_state),
    .write_position (write_position),
    .frame_recorded (frame_recorded),
    .read_0         (read_0),
    .read_1         (read_1),
    .read_2         (read_2),
    .read_3         (read_3),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // result side: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send(input cmd_t c, input frame_t s, input logic [FRAME_W-1:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    sample_0 <= s[0];
    sample_1 <= s[1];
    sample_2 <= s[2];
    sample_3 <= s[3];
    read_index <= ri;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
  endtask

  task automatic apply_setup(input cfg_t c);
    write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(c.trigger_mode));
    write_reg(REG_TRIGGER_LEVEL, c.trigger_level);
    write_reg(REG_TRIGGER_CHANNEL, CFG_DATA_W'(c.trigger_channel));
    write_reg(REG_TRIGGER_OFFSET, CFG_DATA_W'(c.trigger_offset));
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(c.sample_count));
    write_reg(REG_DECIMATION, c.decimation);
    write_reg(REG_AUTO_DELAY, c.auto_delay);
    cfg_write_en <= 1'b0;
  endtask

  function automatic cfg_t pick_setup();
    cfg_t c;
    int   off;
    c.trigger_mode = edge_mode_t'($urandom_range(3));
    c.trigger_level = WORD_W'($urandom_range(65535));
    c.trigger_channel = CHAN_SEL_W'($urandom_range(3));
    case ($urandom_range(9))
      0: c.sample_count = '0;
      1: c.sample_count = SCOUNT_W'(2047);
      2: c.sample_count = SCOUNT_W'(1024);
      3: c.sample_count = SCOUNT_W'($urandom_range(2047));
      default: c.sample_count = SCOUNT_W'($urandom_range(1, 48));
    endcase
    case ($urandom_range(9))
      0: off = int'($urandom_range(8191));
      1: off = $urandom_range(1) ? 4095 : -4096;
      default: off = int'($urandom_range(96)) - 48;
    endcase
    c.trigger_offset = OFFSET_W'(off);
    case ($urandom_range(9))
      0: c.decimation = WORD_W'($urandom_range(65535));
      1: c.decimation = 16'hFFFF;
      default: c.decimation = WORD_W'($urandom_range(3));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: c.auto_delay = '0;
      5, 6, 7: c.auto_delay = WORD_W'($urandom_range(1, 20));
      8: c.auto_delay = WORD_W'($urandom_range(65535));
      default: c.auto_delay = 16'hFFFF;
    endcase
    return c;
  endfunction

  // keep the trigger channel near the level half the time to get crossings
  function automatic frame_t pick_samples(input cfg_t c);
    frame_t f;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      f[ch] = SAMPLE_BITS'($urandom_range(65535));
    end
    if ($urandom_range(1)) begin
      f[c.trigger_channel] = c.trigger_level + SAMPLE_BITS'($urandom_range(6)) - 16'd3;
    end
    return f;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_index();
    return ($urandom_range(9) < 7) ? FRAME_W'($urandom_range(63))
                                   : FRAME_W'($urandom_range(1023));
  endfunction

  initial begin
    cfg_t setup;
    int   r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one long capture writes every frame of the store
    setup = '{TRIG_RISE, 16'h0000, 2'd0, 13'd200, 11'd1024, 16'd0, 16'd0};
    apply_setup(setup);
    send(CMD_START, pick_samples(setup), pick_index());
    send(CMD_MANUAL, pick_samples(setup), pick_index());
    repeat (1030) send(CMD_TICK, pick_samples(setup), pick_index());
    wait_idle();

    // single frame ring, clamped offset, pointer past the ring end
    setup = '{TRIG_RISE, 16'h0000, 2'd1, 13'h0FFF, 11'd0, 16'd0, 16'd0};
    apply_setup(setup);
    send(CMD_READ, pick_samples(setup), 10'd0);
    send(CMD_READ, pick_samples(setup), 10'd1);
    send(CMD_READ, pick_samples(setup), 10'd1023);
    send(CMD_START, pick_samples(setup), 10'd0);
    send(CMD_TICK, {4{16'h8000}}, 10'd0);
    send(CMD_TICK, {4{16'h7FFF}}, 10'h3FF);
    send(CMD_READ, pick_samples(setup), 10'd0);
    wait_idle();

    // falling edge landing on the level, oversized count, most negative offset
    setup = '{TRIG_FALL, 16'h7FFE, 2'd3, 13'h1000, 11'd2047, 16'hFFFF, 16'd1};
    apply_setup(setup);
    send(CMD_START, pick_samples(setup), 10'd0);
    send(CMD_TICK, {16'h7FFF, 16'h0000, 16'hFFFF, 16'h5555}, 10'd0);
    send(CMD_TICK, {16'h7FFE, 16'hAAAA, 16'h0001, 16'h8000}, 10'd0);
    send(CMD_MANUAL, pick_samples(setup), 10'd0);
    send(CMD_TICK, pick_samples(setup), 10'd0);
    send(CMD_READ, pick_samples(setup), 10'd1023);
    wait_idle();

    // no edge trigger, long auto countdown, sticky manual flag
    setup = '{TRIG_NONE, 16'h8000, 2'd2, 13'd0, 11'd1, 16'd0, 16'hFFFF};
    apply_setup(setup);
    send(CMD_MANUAL, pick_samples(setup), 10'd0);
    send(CMD_START, pick_samples(setup), 10'd0);
    send(CMD_TICK, pick_samples(setup), 10'd0);
    send(CMD_MANUAL, pick_samples(setup), 10'd0);
    send(CMD_TICK, pick_samples(setup), 10'd0);
    send(CMD_TICK, pick_samples(setup), 10'd0);
    wait_idle();

    // auto trigger firing with decimation
    setup = '{TRIG_BOTH, 16'h0000, 2'd0, 13'd2, 11'd4, 16'd1, 16'd1};
    apply_setup(setup);
    send(CMD_START, pick_samples(setup), 10'd0);
    repeat (6) send(CMD_TICK, {4{16'h0123}}, 10'd0);
    send(CMD_READ, pick_samples(setup), 10'd3);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      setup = pick_setup();
      apply_setup(setup);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph == 4) begin
        @(posedge clk);
        hold_req = 300;
        @(negedge clk);
      end
      send(CMD_START, pick_samples(setup), pick_index());
      for (int k = 0; k < 15; k++) begin
        if (ph == 6 && k == 7) wait_idle();
        r = $urandom_range(99);
        if (r < 6) send(CMD_START, pick_samples(setup), pick_index());
        else if (r < 11) send(CMD_MANUAL, pick_samples(setup), pick_index());
        else if (r < 22) send(CMD_READ, pick_samples(setup), pick_index());
        else send(CMD_TICK, pick_samples(setup), pick_index());
      end
    end

    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
